### hw/rtl/klcg_pkg.sv
// ----------------------------------------------------------------------------
// klcg_pkg
// shared types and constants for the keyed lcg byte-stream cipher
// ----------------------------------------------------------------------------
package klcg_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN_KEY = 3'd0,
		CMD_KEY_BYTE  = 3'd1,
		CMD_END_KEY   = 3'd2,
		CMD_RESTART   = 3'd3,
		CMD_DATA      = 3'd4
	} klcg_cmd_t;

	// key absorb constants
	localparam logic [63:0] KEY_MUL_EVEN   = 64'd131;
	localparam logic [63:0] KEY_MUL_ODD    = 64'd137;
	localparam int unsigned KEY_SHIFT_EVEN = 3;
	localparam int unsigned KEY_SHIFT_ODD  = 5;

	// keystream lcg, multiplier split into 32-bit halves
	localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
	localparam logic [31:0] LCG_MUL_HI = 32'h0000_0005;
	localparam logic [63:0] LCG_ADD    = 64'h0000_0000_0000_000B;

	// result word handed from the core to the output buffer
	typedef struct packed {
		logic       push;
		logic [7:0] data;
	} klcg_result_t;

endpackage

### hw/rtl/klcg_lcg_step.sv
// ----------------------------------------------------------------------------
// klcg_lcg_step
// one step of the 64-bit wrapping keystream lcg, built from 32-bit products
// ----------------------------------------------------------------------------
module klcg_lcg_step (
	input  logic [63:0] word,
	output logic [63:0] next_word
);
	import klcg_pkg::*;

	logic [63:0] prod_lo_lo;
	logic [31:0] prod_hi_lo;
	logic [31:0] prod_lo_hi;
	logic [31:0] cross_sum;

	// x*m mod 2^64 = lo*m_lo + 2^32*(hi*m_lo + lo*m_hi)
	assign prod_lo_lo = {32'b0, word[31:0]} * {32'b0, LCG_MUL_LO};
	assign prod_hi_lo = word[63:32] * LCG_MUL_LO;
	assign prod_lo_hi = word[31:0] * LCG_MUL_HI;
	assign cross_sum  = prod_hi_lo + prod_lo_hi;
	assign next_word  = prod_lo_lo + {cross_sum, 32'b0} + LCG_ADD;

endmodule

### hw/rtl/klcg_core.sv
// ----------------------------------------------------------------------------
// klcg_core
// input register, key hash and keystream state, result generation
// ----------------------------------------------------------------------------
module klcg_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            command,
	input  logic [7:0]            data_in,
	input  logic                  buf_ready,
	output klcg_pkg::klcg_result_t result
);
	import klcg_pkg::*;

	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [7:0]  data_s1;

	logic [63:0] key_high_q, key_low_q, stream_word_q;
	logic        key_parity_q;
	logic [2:0]  byte_pos_q;

	logic [63:0] key_high_d, key_low_d, stream_word_d;
	logic        key_parity_d;
	logic [2:0]  byte_pos_d;

	logic [63:0] mixed_high, mixed_low, lcg_next;
	logic        is_data, proceed, take;

	assign is_data  = (klcg_cmd_t'(command_s1) == CMD_DATA);
	assign proceed  = valid_s1 && (!is_data || buf_ready);
	assign in_stall = valid_s1 && !proceed;
	assign take     = in_valid && !in_stall;

	// end-key cross mix
	assign mixed_high = key_high_q ^ {key_low_q[50:0], key_low_q[63:51]};
	assign mixed_low  = key_low_q ^ {mixed_high[56:0], mixed_high[63:57]};

	klcg_lcg_step u_lcg (
		.word      (stream_word_q),
		.next_word (lcg_next)
	);

	always_comb begin
		key_high_d    = key_high_q;
		key_low_d     = key_low_q;
		key_parity_d  = key_parity_q;
		stream_word_d = stream_word_q;
		byte_pos_d    = byte_pos_q;
		case (klcg_cmd_t'(command_s1))
			CMD_BEGIN_KEY: begin
				key_high_d   = '0;
				key_low_d    = '0;
				key_parity_d = 1'b0;
			end
			CMD_KEY_BYTE: begin
				if (!key_parity_q) begin
					key_high_d = (key_high_q * KEY_MUL_EVEN)
						^ ({56'b0, data_s1} + (key_high_q >> KEY_SHIFT_EVEN));
				end else begin
					key_low_d = (key_low_q * KEY_MUL_ODD)
						^ ({56'b0, data_s1} + (key_low_q >> KEY_SHIFT_ODD));
				end
				key_parity_d = !key_parity_q;
			end
			CMD_END_KEY: begin
				key_high_d    = mixed_high;
				key_low_d     = mixed_low;
				stream_word_d = mixed_high ^ mixed_low;
				byte_pos_d    = '0;
			end
			CMD_RESTART: begin
				stream_word_d = key_high_q ^ key_low_q;
				byte_pos_d    = '0;
			end
			CMD_DATA: begin
				stream_word_d = lcg_next;
				byte_pos_d    = byte_pos_q + 3'd1;
			end
			default: begin
			end
		endcase
	end

	assign result.push = proceed && is_data;
	assign result.data = data_s1 ^ stream_word_q[{byte_pos_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			command_s1 <= command;
			data_s1    <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q    <= '0;
			key_low_q     <= '0;
			key_parity_q  <= 1'b0;
			stream_word_q <= '0;
			byte_pos_q    <= '0;
		end else if (proceed) begin
			key_high_q    <= key_high_d;
			key_low_q     <= key_low_d;
			key_parity_q  <= key_parity_d;
			stream_word_q <= stream_word_d;
			byte_pos_q    <= byte_pos_d;
		end
	end

endmodule

### hw/rtl/klcg_out_buf.sv
// ----------------------------------------------------------------------------
// klcg_out_buf
// two-entry output buffer, ready is taken from registered fill state
// ----------------------------------------------------------------------------
module klcg_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  klcg_pkg::klcg_result_t result,
	output logic                  buf_ready,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            data_out
);
	import klcg_pkg::*;

	logic [7:0] entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign buf_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign data_out  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (result.push) begin
			entry_q[wr_ptr_q] <= result.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (result.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({result.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/keyed_lcg_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// keyed_lcg_stream_cipher_top
// keyed byte-stream cipher: key hashing, keystream lcg, xor of data bytes
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle, sustained as long as the output
// side keeps up. Each word carries a command and a byte: begin key, key byte,
// end key, restart message or data byte. Only data bytes give an output word,
// the byte xored with the current keystream byte; encryption and decryption
// are the same operation. A word goes through an input register; while it
// is held there, all state updates and the output byte are formed, and
// once the buffer has room the byte is written into a two-entry output
// buffer, which presents it as the output word.
// The cycle time is set by the keystream lcg step (two 32x32 constant
// products, a small product by five and a 64-bit add), which is combinational
// from the registered keystream word. Stall on the output side reaches the
// input stall only through the registered buffer fill state.
module keyed_lcg_stream_cipher_top (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] data_in,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_out
);
	import klcg_pkg::*;

	// result word from the core and room flag from the buffer
	klcg_result_t result;
	logic         buf_ready;

	// input register, key words, keystream word and byte position
	klcg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.data_in   (data_in),
		.buf_ready (buf_ready),
		.result    (result)
	);

	// output buffer decouples the output stall from the core
	klcg_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.buf_ready (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out)
	);

endmodule
